// ===== rtl/core/rts_pkg.sv =====
`default_nettype none

package rts_pkg;

    localparam int TEMP_BITS     = 16;
    localparam int COUNT_BITS    = 7;
    localparam int SUM_BITS      = TEMP_BITS + COUNT_BITS;
    localparam int MAG_BITS      = SUM_BITS - 1;
    localparam int INDEX_BITS    = 6;
    localparam int MASK_BITS     = 64;
    localparam int MASK_REGS     = 4;
    localparam int ENABLE_BITS   = 4;
    localparam int CHAN_NUM_BITS = 2;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 64;
    localparam int CHANNELS_DEF  = 4;
    localparam int PIXELS_DEF    = 64;

    typedef logic [CFG_ADDR_BITS-1:0] reg_addr_t;

    localparam reg_addr_t REG_OFFSET = 3'd0;
    localparam reg_addr_t REG_ENABLE = 3'd1;
    localparam reg_addr_t REG_MASK_A = 3'd2;
    localparam reg_addr_t REG_MASK_B = 3'd3;
    localparam reg_addr_t REG_MASK_C = 3'd4;
    localparam reg_addr_t REG_MASK_D = 3'd5;

    localparam logic signed [TEMP_BITS-1:0] TEMP_MAX = {1'b0, {(TEMP_BITS-1){1'b1}}};
    localparam logic signed [TEMP_BITS-1:0] TEMP_MIN = {1'b1, {(TEMP_BITS-1){1'b0}}};
    localparam logic [COUNT_BITS-1:0]       COUNT_CAP = '1;

    typedef struct packed {
        logic                         avail;
        logic signed [TEMP_BITS-1:0]  min_t;
        logic signed [TEMP_BITS-1:0]  max_t;
        logic signed [SUM_BITS-1:0]   sum;
        logic [COUNT_BITS-1:0]        count;
    } cell_state_t;

    localparam cell_state_t CELL_CLEAR = '{
        avail: 1'b0,
        min_t: TEMP_MAX,
        max_t: TEMP_MIN,
        sum:   '0,
        count: '0
    };

    typedef struct packed {
        logic                         take;
        logic                         last;
        logic                         frame_good;
        logic signed [TEMP_BITS-1:0]  temp;
    } pixel_bcast_t;

    typedef struct packed {
        logic enable;
        logic hit;
        logic mask_any;
    } chan_sel_t;

    typedef struct packed {
        logic                  start;
        logic [COUNT_BITS-1:0] divisor;
        logic [MAG_BITS-1:0]   dividend;
    } div_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/rts_cell.sv =====
`default_nettype none

module rts_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rts_pkg::pixel_bcast_t pixel,
    input  wire rts_pkg::chan_sel_t   sel,
    input  wire logic                 shift,
    input  wire rts_pkg::cell_state_t next_state,
    output rts_pkg::cell_state_t      state
);

    rts_pkg::cell_state_t state_reg;
    rts_pkg::cell_state_t state_next;
    logic                 upd;
    logic signed [rts_pkg::SUM_BITS-1:0] temp_ext;

    assign temp_ext = {{(rts_pkg::SUM_BITS-rts_pkg::TEMP_BITS){pixel.temp[rts_pkg::TEMP_BITS-1]}},
                       pixel.temp};
    assign upd = pixel.take & sel.enable & sel.hit & (state_reg.count != rts_pkg::COUNT_CAP);

    always_comb
    begin
        state_next = state_reg;
        if (shift)
        begin
            // drain: take the neighbor's contents, the tail refills with clear values
            state_next = next_state;
        end
        else
        begin
            if (upd)
            begin
                if ($signed(pixel.temp) < $signed(state_reg.min_t))
                begin
                    state_next.min_t = pixel.temp;
                end
                if ($signed(pixel.temp) > $signed(state_reg.max_t))
                begin
                    state_next.max_t = pixel.temp;
                end
                state_next.sum   = state_reg.sum + temp_ext;
                state_next.count = state_reg.count + rts_pkg::COUNT_BITS'(1);
            end
            if (pixel.last)
            begin
                state_next.avail = pixel.frame_good & sel.enable & sel.mask_any;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rts_pkg::CELL_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rts_div.sv =====
`default_nettype none

module rts_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rts_pkg::div_req_t             req,
    output logic                               done,
    output logic [rts_pkg::MAG_BITS-1:0]       quotient
);

    localparam int STEP_BITS = $clog2(rts_pkg::MAG_BITS);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(rts_pkg::MAG_BITS - 1);

    logic [rts_pkg::COUNT_BITS-1:0] divisor_reg;
    logic [rts_pkg::COUNT_BITS-1:0] rem_reg;
    logic [rts_pkg::MAG_BITS-1:0]   quo_reg;
    logic [STEP_BITS-1:0]           step_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [rts_pkg::COUNT_BITS:0]   trial;
    logic [rts_pkg::COUNT_BITS:0]   diff;
    logic                           fits;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[rts_pkg::MAG_BITS-1]};
    assign fits  = trial >= {1'b0, divisor_reg};
    assign diff  = trial - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == LAST_STEP);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_BITS'(1);
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            divisor_reg <= req.divisor;
            quo_reg     <= req.dividend;
            rem_reg     <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[rts_pkg::COUNT_BITS-1:0] : trial[rts_pkg::COUNT_BITS-1:0];
            quo_reg <= {quo_reg[rts_pkg::MAG_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/roi_temperature_statistics_top.sv =====
// Region-of-interest temperature statistics. Pixels of a frame arrive one per cycle, while
// in_ready is high, on the input channel; each enabled channel whose region mask selects a
// pixel flagged pixel_ok updates its minimum, maximum, sum and count, held in one cell per
// channel. The item flagged last_pixel closes the frame: the block then stops taking items
// and emits CHANNELS results, channel 0 first, by shifting the cell row toward its head. Each
// result passes through S_LOAD (head cell into the bit-serial mean divider), S_DIV (divider
// runs until done) and S_OUT (held until out_ready). The shift leaves every cell cleared for
// the next frame. Configuration is written through cfg_we / cfg_addr / cfg_wdata.
`default_nettype none

module roi_temperature_statistics_top #(
    parameter int CHANNELS = rts_pkg::CHANNELS_DEF,
    parameter int PIXELS   = rts_pkg::PIXELS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  cfg_we,
    input  wire logic [rts_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  wire logic [rts_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,

    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [rts_pkg::INDEX_BITS-1:0]        pixel_index,
    input  wire logic signed [rts_pkg::TEMP_BITS-1:0]  temperature,
    input  wire logic                                  pixel_ok,
    input  wire logic                                  frame_ok,
    input  wire logic                                  last_pixel,

    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [rts_pkg::CHAN_NUM_BITS-1:0]          channel_number,
    output logic                                       available,
    output logic signed [rts_pkg::TEMP_BITS-1:0]       min_temperature,
    output logic signed [rts_pkg::TEMP_BITS-1:0]       max_temperature,
    output logic signed [rts_pkg::TEMP_BITS-1:0]       mean_temperature,
    output logic [rts_pkg::COUNT_BITS-1:0]             pixel_count,
    output logic                                       last_result
);

    localparam int CH_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_BITS-1:0] LAST_CH = CH_BITS'(CHANNELS - 1);
    localparam int TB = rts_pkg::TEMP_BITS;

    typedef enum logic [3:0] {
        S_ACCUM = 4'b0001,
        S_LOAD  = 4'b0010,
        S_DIV   = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic signed [TB-1:0]                  offset_reg;
    logic [rts_pkg::ENABLE_BITS-1:0]       enable_reg;
    logic [rts_pkg::MASK_BITS-1:0]         mask_reg [rts_pkg::MASK_REGS];

    logic                                  frame_good_reg;
    logic [CH_BITS-1:0]                    ch_reg;

    // result held while the divider runs
    logic                                  hold_avail_reg;
    logic                                  hold_neg_reg;
    logic signed [TB-1:0]                  hold_min_reg;
    logic signed [TB-1:0]                  hold_max_reg;
    logic [rts_pkg::COUNT_BITS-1:0]        hold_count_reg;

    // output register
    logic                                  out_valid_reg;
    logic [rts_pkg::CHAN_NUM_BITS-1:0]     chan_num_reg;
    logic                                  avail_out_reg;
    logic signed [TB-1:0]                  min_out_reg;
    logic signed [TB-1:0]                  max_out_reg;
    logic signed [TB-1:0]                  mean_out_reg;
    logic [rts_pkg::COUNT_BITS-1:0]        count_out_reg;
    logic                                  last_out_reg;

    logic                                  accept;
    logic signed [TB:0]                    cal_sum;
    logic signed [TB-1:0]                  cal_temp;
    logic                                  in_frame;
    rts_pkg::pixel_bcast_t                 pixel;
    rts_pkg::chan_sel_t                    sel      [CHANNELS];
    rts_pkg::cell_state_t                  cell_q   [CHANNELS];
    rts_pkg::cell_state_t                  chain_in [CHANNELS];
    logic                                  shift;

    rts_pkg::div_req_t                     div_req;
    logic                                  div_done;
    logic [rts_pkg::MAG_BITS-1:0]          div_quo;
    logic [rts_pkg::SUM_BITS-1:0]          head_mag;
    logic [rts_pkg::MAG_BITS-1:0]          mean_mag;

    assign accept   = in_valid & in_ready;
    assign in_ready = (state_reg == S_ACCUM);
    assign shift    = (state_reg == S_LOAD);

    // saturating calibration
    assign cal_sum = {offset_reg[TB-1], offset_reg} + {temperature[TB-1], temperature};
    always_comb
    begin
        if (cal_sum[TB] != cal_sum[TB-1])
        begin
            cal_temp = cal_sum[TB] ? rts_pkg::TEMP_MIN : rts_pkg::TEMP_MAX;
        end
        else
        begin
            cal_temp = cal_sum[TB-1:0];
        end
    end

    assign in_frame = ({1'b0, pixel_index} < (rts_pkg::INDEX_BITS+1)'(PIXELS));

    assign pixel.take       = accept & pixel_ok & in_frame;
    assign pixel.last       = accept & last_pixel;
    assign pixel.frame_good = frame_good_reg & frame_ok;
    assign pixel.temp       = cal_temp;

    genvar gi;
    generate
        for (gi = 0; gi < CHANNELS; gi++)
        begin : g_cell
            if (gi < rts_pkg::MASK_REGS)
            begin : g_sel
                assign sel[gi].enable   = enable_reg[gi];
                assign sel[gi].hit      = mask_reg[gi][pixel_index];
                assign sel[gi].mask_any = |mask_reg[gi];
            end
            else
            begin : g_nosel
                assign sel[gi] = '0;
            end

            if (gi == CHANNELS - 1)
            begin : g_tail
                assign chain_in[gi] = rts_pkg::CELL_CLEAR;
            end
            else
            begin : g_link
                assign chain_in[gi] = cell_q[gi+1];
            end

            rts_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .pixel      (pixel),
                .sel        (sel[gi]),
                .shift      (shift),
                .next_state (chain_in[gi]),
                .state      (cell_q[gi])
            );
        end
    endgenerate

    // divider works on magnitudes; sign is restored on the quotient
    assign head_mag = cell_q[0].sum[rts_pkg::SUM_BITS-1] ? (rts_pkg::SUM_BITS'(0) - cell_q[0].sum)
                                                         : cell_q[0].sum;

    assign div_req.start    = shift;
    assign div_req.divisor  = cell_q[0].count;
    assign div_req.dividend = head_mag[rts_pkg::MAG_BITS-1:0];

    rts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign mean_mag = hold_neg_reg ? (rts_pkg::MAG_BITS'(0) - div_quo) : div_quo;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            enable_reg <= '0;
            for (int i = 0; i < rts_pkg::MASK_REGS; i++)
            begin
                mask_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr) inside
                rts_pkg::REG_OFFSET:
                begin
                    offset_reg <= cfg_wdata[TB-1:0];
                end
                rts_pkg::REG_ENABLE:
                begin
                    enable_reg <= cfg_wdata[rts_pkg::ENABLE_BITS-1:0];
                end
                rts_pkg::REG_MASK_A, rts_pkg::REG_MASK_B, rts_pkg::REG_MASK_C,
                rts_pkg::REG_MASK_D:
                begin
                    mask_reg[2'(cfg_addr - rts_pkg::REG_MASK_A)] <= cfg_wdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_ACCUM:
            begin
                if (accept && last_pixel)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = (ch_reg == LAST_CH) ? S_ACCUM : S_LOAD;
                end
            end
            default:
            begin
                state_next = S_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_ACCUM;
            frame_good_reg <= 1'b1;
            ch_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (last_pixel)
                begin
                    frame_good_reg <= 1'b1;
                    ch_reg         <= '0;
                end
                else if (!frame_ok)
                begin
                    frame_good_reg <= 1'b0;
                end
            end
            if (state_reg == S_DIV && div_done)
            begin
                out_valid_reg <= 1'b1;
            end
            if (state_reg == S_OUT && out_ready)
            begin
                out_valid_reg <= 1'b0;
                if (ch_reg != LAST_CH)
                begin
                    ch_reg <= ch_reg + CH_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            hold_avail_reg <= cell_q[0].avail & (cell_q[0].count != '0);
            hold_neg_reg   <= cell_q[0].sum[rts_pkg::SUM_BITS-1];
            hold_min_reg   <= cell_q[0].min_t;
            hold_max_reg   <= cell_q[0].max_t;
            hold_count_reg <= cell_q[0].count;
        end
        if (state_reg == S_DIV && div_done)
        begin
            chan_num_reg  <= rts_pkg::CHAN_NUM_BITS'(ch_reg);
            avail_out_reg <= hold_avail_reg;
            last_out_reg  <= (ch_reg == LAST_CH);
            if (hold_avail_reg)
            begin
                min_out_reg   <= hold_min_reg;
                max_out_reg   <= hold_max_reg;
                mean_out_reg  <= mean_mag[TB-1:0];
                count_out_reg <= hold_count_reg;
            end
            else
            begin
                min_out_reg   <= '0;
                max_out_reg   <= '0;
                mean_out_reg  <= '0;
                count_out_reg <= '0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign channel_number   = chan_num_reg;
    assign available        = avail_out_reg;
    assign min_temperature  = min_out_reg;
    assign max_temperature  = max_out_reg;
    assign mean_temperature = mean_out_reg;
    assign pixel_count      = count_out_reg;
    assign last_result      = last_out_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    a_avail_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && available) |-> (pixel_count != '0))
        else $error("available result with zero pixel count");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && available) |-> ($signed(min_temperature) <= $signed(max_temperature)))
        else $error("minimum above maximum");

    a_last_chan: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_result) |-> (channel_number == rts_pkg::CHAN_NUM_BITS'(CHANNELS - 1)))
        else $error("last result on wrong channel");

endmodule

`default_nettype wire

// ===== sim/roi_temperature_statistics_top_test.sv =====
`timescale 1ns / 1ps

typedef struct packed {
    logic [rts_pkg::INDEX_BITS-1:0]       idx;
    logic signed [rts_pkg::TEMP_BITS-1:0] temp;
    logic                                 pok;
    logic                                 fok;
    logic                                 last;
} pixel_t;

typedef struct packed {
    logic [rts_pkg::CHAN_NUM_BITS-1:0]    chan;
    logic                                 avail;
    logic signed [rts_pkg::TEMP_BITS-1:0] lo;
    logic signed [rts_pkg::TEMP_BITS-1:0] hi;
    logic signed [rts_pkg::TEMP_BITS-1:0] mean;
    logic [rts_pkg::COUNT_BITS-1:0]       count;
    logic                                 last;
} roi_stats_t;

class channel_stats_tracker;
    logic signed [rts_pkg::TEMP_BITS-1:0] offset;
    logic [rts_pkg::ENABLE_BITS-1:0]      enable;
    logic [rts_pkg::MASK_BITS-1:0]        mask [rts_pkg::MASK_REGS];

    logic signed [rts_pkg::TEMP_BITS-1:0] lo [rts_pkg::CHANNELS_DEF];
    logic signed [rts_pkg::TEMP_BITS-1:0] hi [rts_pkg::CHANNELS_DEF];
    logic signed [rts_pkg::SUM_BITS-1:0]  total [rts_pkg::CHANNELS_DEF];
    logic [rts_pkg::COUNT_BITS-1:0]       hits [rts_pkg::CHANNELS_DEF];
    bit                                   frame_good;

    roi_stats_t expected_stats [$];
    int errors;
    int results_checked;
    int available_checked;

    function new();
        offset = '0;
        enable = '0;
        foreach (mask[i]) mask[i] = '0;
        errors = 0;
        results_checked = 0;
        available_checked = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        for (int c = 0; c < rts_pkg::CHANNELS_DEF; c++) begin
            lo[c]    = rts_pkg::TEMP_MAX;
            hi[c]    = rts_pkg::TEMP_MIN;
            total[c] = '0;
            hits[c]  = '0;
        end
        frame_good = 1'b1;
    endfunction

    function void write_reg(rts_pkg::reg_addr_t addr,
                            logic [rts_pkg::CFG_DATA_BITS-1:0] data);
        case (addr)
            rts_pkg::REG_OFFSET: offset  = data[rts_pkg::TEMP_BITS-1:0];
            rts_pkg::REG_ENABLE: enable  = data[rts_pkg::ENABLE_BITS-1:0];
            rts_pkg::REG_MASK_A: mask[0] = data;
            rts_pkg::REG_MASK_B: mask[1] = data;
            rts_pkg::REG_MASK_C: mask[2] = data;
            rts_pkg::REG_MASK_D: mask[3] = data;
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_stats.size();
    endfunction

    // Fold one accepted pixel into the running statistics; on the last pixel
    // queue one result per channel and start a fresh frame.
    function void take_pixel(pixel_t p);
        int t;
        int m;
        roi_stats_t r;
        if (!p.fok)
            frame_good = 1'b0;
        if (p.pok) begin
            t = int'(p.temp) + int'(offset);
            if (t > 32767)
                t = 32767;
            if (t < -32768)
                t = -32768;
            for (int c = 0; c < rts_pkg::CHANNELS_DEF; c++) begin
                if (enable[c] && mask[c][p.idx] && hits[c] != rts_pkg::COUNT_CAP) begin
                    if (t < lo[c])
                        lo[c] = t[rts_pkg::TEMP_BITS-1:0];
                    if (t > hi[c])
                        hi[c] = t[rts_pkg::TEMP_BITS-1:0];
                    total[c] = total[c] + t;
                    hits[c]  = hits[c] + 1'b1;
                end
            end
        end
        if (!p.last)
            return;
        for (int c = 0; c < rts_pkg::CHANNELS_DEF; c++) begin
            r       = '0;
            r.chan  = c[rts_pkg::CHAN_NUM_BITS-1:0];
            r.avail = frame_good && enable[c] && (mask[c] != '0) && (hits[c] != '0);
            if (r.avail) begin
                m       = int'(total[c]) / int'(hits[c]);
                r.lo    = lo[c];
                r.hi    = hi[c];
                r.mean  = m[rts_pkg::TEMP_BITS-1:0];
                r.count = hits[c];
            end
            r.last = (c == rts_pkg::CHANNELS_DEF - 1);
            expected_stats.push_back(r);
        end
        clear_frame();
    endfunction

    function string fmt(roi_stats_t r);
        return $sformatf("ch %0d avail %0d min %0d max %0d mean %0d count %0d last %0d",
                         r.chan, r.avail, r.lo, r.hi, r.mean, r.count, r.last);
    endfunction

    function void report(string msg);
        errors++;
        if (errors <= 10)
            $display("MISMATCH: %s", msg);
    endfunction

    function void check_channel_result(roi_stats_t got);
        roi_stats_t want;
        string bad;
        bad = "";
        if (expected_stats.size() == 0) begin
            report({"unexpected result ", fmt(got)});
            return;
        end
        want = expected_stats.pop_front();
        results_checked++;
        if (want.avail)
            available_checked++;
        if (got.chan !== want.chan)
            bad = {bad, " channel_number"};
        if (got.avail !== want.avail)
            bad = {bad, " available"};
        if (got.lo !== want.lo)
            bad = {bad, " min_temperature"};
        if (got.hi !== want.hi)
            bad = {bad, " max_temperature"};
        if (got.mean !== want.mean)
            bad = {bad, " mean_temperature"};
        if (got.count !== want.count)
            bad = {bad, " pixel_count"};
        if (got.last !== want.last)
            bad = {bad, " last_result"};
        if (bad != "")
            report({"field(s)", bad, ": expected ", fmt(want), ", got ", fmt(got)});
    endfunction

    function void drain_check();
        while (expected_stats.size() != 0)
            report({"missing result ", fmt(expected_stats.pop_front())});
    endfunction
endclass

module roi_temperature_statistics_top_test;

    localparam int                 ITEM_TARGET  = 410;
    localparam int                 QUIET_FROM   = 340;
    localparam int                 DRAIN_CYCLES = 40;
    localparam int                 CYCLE_LIMIT  = 200000;
    localparam rts_pkg::reg_addr_t REG_SPARE    = 3'd6;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   cfg_we = 1'b0;
    logic [rts_pkg::CFG_ADDR_BITS-1:0]      cfg_addr = '0;
    logic [rts_pkg::CFG_DATA_BITS-1:0]      cfg_wdata = '0;
    logic                                   in_valid = 1'b0;
    logic                                   in_ready;
    logic [rts_pkg::INDEX_BITS-1:0]         pixel_index = '0;
    logic signed [rts_pkg::TEMP_BITS-1:0]   temperature = '0;
    logic                                   pixel_ok = 1'b0;
    logic                                   frame_ok = 1'b0;
    logic                                   last_pixel = 1'b0;
    logic                                   out_valid;
    logic                                   out_ready = 1'b0;
    logic [rts_pkg::CHAN_NUM_BITS-1:0]      channel_number;
    logic                                   available;
    logic signed [rts_pkg::TEMP_BITS-1:0]   min_temperature;
    logic signed [rts_pkg::TEMP_BITS-1:0]   max_temperature;
    logic signed [rts_pkg::TEMP_BITS-1:0]   mean_temperature;
    logic [rts_pkg::COUNT_BITS-1:0]         pixel_count;
    logic                                   last_result;

    channel_stats_tracker tracker = new();

    int cycle_count = 0;
    int pixels_sent = 0;
    int frames_sent = 0;
    int settings_applied = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int ready_hold = 0;
    bit quiet = 1'b0;

    roi_temperature_statistics_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .pixel_index      (pixel_index),
        .temperature      (temperature),
        .pixel_ok         (pixel_ok),
        .frame_ok         (frame_ok),
        .last_pixel       (last_pixel),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .channel_number   (channel_number),
        .available        (available),
        .min_temperature  (min_temperature),
        .max_temperature  (max_temperature),
        .mean_temperature (mean_temperature),
        .pixel_count      (pixel_count),
        .last_result      (last_result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Output back-pressure in random bursts
    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold = ready_hold - 1;
        else if (quiet || $urandom_range(99) >= stall_pct)
        begin
            out_ready <= 1'b1;
            ready_hold = $urandom_range(1, 20);
        end
        else
        begin
            out_ready <= 1'b0;
            ready_hold = $urandom_range(0, 13);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_channel_result(roi_stats_t'{channel_number, available,
                min_temperature, max_temperature, mean_temperature, pixel_count,
                last_result});
    end

    task automatic write_reg(input rts_pkg::reg_addr_t addr,
                             input logic [rts_pkg::CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        tracker.write_reg(addr, data);
    endtask

    task automatic apply_config(input logic [63:0] off_word, input logic [63:0] en_word,
                                input logic [63:0] m0, input logic [63:0] m1,
                                input logic [63:0] m2, input logic [63:0] m3);
        write_reg(rts_pkg::REG_OFFSET, off_word);
        write_reg(rts_pkg::REG_ENABLE, en_word);
        write_reg(rts_pkg::REG_MASK_A, m0);
        write_reg(rts_pkg::REG_MASK_B, m1);
        write_reg(rts_pkg::REG_MASK_C, m2);
        write_reg(rts_pkg::REG_MASK_D, m3);
        // unmapped index must not disturb anything
        write_reg(REG_SPARE, {$urandom, $urandom});
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Drop valid and let the block drain before touching registers
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_pixel(input pixel_t p);
        if (!quiet && idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_index <= p.idx;
        temperature <= p.temp;
        pixel_ok    <= p.pok;
        frame_ok    <= p.fok;
        last_pixel  <= p.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.take_pixel(p);
        pixels_sent++;
    endtask

    function automatic logic [63:0] offset_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(4))
            0: w[15:0] = 16'h0000;
            1: w[15:0] = 16'h7FFF;
            2: w[15:0] = 16'h8000;
            3: w[15:0] = 16'($urandom_range(0, 600)) - 16'd300;
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [63:0] enable_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        if ($urandom_range(2) == 0)
            w[3:0] = 4'hF;
        return w;
    endfunction

    function automatic logic [63:0] mask_word();
        logic [63:0] w;
        case ($urandom_range(5))
            0: w = '1;
            1: w = '0;
            2: w = 64'd1 << $urandom_range(63);
            3: w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        p.idx  = rts_pkg::INDEX_BITS'($urandom);
        p.pok  = ($urandom_range(9) != 0);
        p.fok  = 1'b1;
        p.last = 1'b0;
        case ($urandom_range(9))
            0: p.temp = 16'sh7FFF;
            1: p.temp = 16'sh8000;
            2, 3, 4: p.temp = rts_pkg::TEMP_BITS'($urandom);
            default: p.temp = rts_pkg::TEMP_BITS'($urandom_range(0, 2000)) - 16'sd1000;
        endcase
        return p;
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    initial
    begin : stimulus
        int     rf;
        int     len;
        int     bad_at;
        int     long_at;
        bit     long_frame;
        pixel_t p;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, empty mask, truncation of a negative mean
        apply_config(64'd0, 64'hF, '1, '0, 64'h8000_0000_0000_0001, 64'hFFFF_FFFF_0000_0000);
        send_pixel(pixel_t'{6'd0,  16'sh8000, 1'b1, 1'b1, 1'b0});
        send_pixel(pixel_t'{6'd63, 16'sh7FFF, 1'b1, 1'b1, 1'b0});
        send_pixel(pixel_t'{6'd1,  -16'sd1,   1'b0, 1'b1, 1'b0});
        send_pixel(pixel_t'{6'd32, -16'sd3,   1'b1, 1'b1, 1'b0});
        send_pixel(pixel_t'{6'd40, -16'sd4,   1'b1, 1'b1, 1'b1});
        // invalid frame
        send_pixel(pixel_t'{6'd5, 16'sd100, 1'b1, 1'b1, 1'b0});
        send_pixel(pixel_t'{6'd6, 16'sd200, 1'b1, 1'b0, 1'b0});
        send_pixel(pixel_t'{6'd7, 16'sd300, 1'b1, 1'b1, 1'b1});
        // nothing counted
        send_pixel(pixel_t'{6'd0, 16'sd50, 1'b0, 1'b1, 1'b1});
        frames_sent += 3;
        settle();

        // positive saturation, half the channels enabled
        apply_config(64'h7FFF, 64'h5, '1, '1, '1, '1);
        send_pixel(pixel_t'{6'd10, 16'sd1,     1'b1, 1'b1, 1'b0});
        send_pixel(pixel_t'{6'd11, 16'sh8000,  1'b1, 1'b1, 1'b0});
        send_pixel(pixel_t'{6'd12, -16'sd20000, 1'b1, 1'b1, 1'b1});
        settle();

        // negative saturation
        apply_config(64'hFFFF_FFFF_FFFF_8000, 64'hA, '0, '1, '0, 64'h5555_5555_5555_5555);
        send_pixel(pixel_t'{6'd20, -16'sd1,   1'b1, 1'b1, 1'b0});
        send_pixel(pixel_t'{6'd21, 16'sh7FFF, 1'b1, 1'b1, 1'b0});
        send_pixel(pixel_t'{6'd3,  16'sh8000, 1'b1, 1'b1, 1'b1});
        settle();

        // all channels disabled
        apply_config(64'd0, 64'd0, '1, '1, '1, '1);
        send_pixel(pixel_t'{6'd0, 16'sd5, 1'b1, 1'b1, 1'b0});
        send_pixel(pixel_t'{6'd1, 16'sd6, 1'b1, 1'b1, 1'b1});
        frames_sent += 3;

        // random frames; one long frame drives the counts into saturation
        rf = 0;
        long_at = $urandom_range(2, 6);
        while (pixels_sent < ITEM_TARGET)
        begin
            quiet = (pixels_sent >= QUIET_FROM);
            long_frame = (rf == long_at);
            if (long_frame)
            begin
                settle();
                apply_config({48'(0), 16'($urandom_range(0, 200)) - 16'd100}, 64'hF,
                             '1, mask_word(), '1, mask_word());
            end
            else if (rf == 0 || $urandom_range(2) == 0)
            begin
                settle();
                apply_config(offset_word(), enable_word(), mask_word(), mask_word(),
                             mask_word(), mask_word());
            end
            idle_pct  = pick_pct();
            stall_pct = pick_pct();
            if (long_frame)
                len = $urandom_range(130, 145);
            else if ($urandom_range(9) == 0)
                len = $urandom_range(17, 64);
            else
                len = $urandom_range(1, 16);
            bad_at = ($urandom_range(99) < 15) ? $urandom_range(0, len - 1) : -1;
            for (int i = 0; i < len; i++)
            begin
                p = random_pixel();
                p.fok  = (i != bad_at);
                p.last = (i == len - 1);
                if (long_frame)
                    p.pok = 1'b1;
                send_pixel(p);
            end
            frames_sent++;
            rf++;
        end

        settle();
        tracker.drain_check();
        $display("Covered %0d pixels in %0d frames under %0d register settings;",
                 pixels_sent, frames_sent, settings_applied);
        $display("checked %0d channel results, %0d of them available, %0d mismatches.",
                 tracker.results_checked, tracker.available_checked, tracker.errors);
        if (tracker.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rts_pkg.sv
rtl/core/rts_cell.sv
rtl/core/rts_div.sv
rtl/core/roi_temperature_statistics_top.sv
sim/roi_temperature_statistics_top_test.sv
